>>> hw/rtl/i4gq_pkg.sv
// Shared constants and types for the int4 group quantiser
`default_nettype none
package i4gq_pkg;
	localparam int GroupSize = 64;
	localparam int IdxW = $clog2(GroupSize);
	localparam int NBytes = (GroupSize + 1) / 2;
	localparam logic [31:0] ScaleFloor = 32'h322BCC77; // 1e-8f
	localparam logic [31:0] SevenF = 32'h40E00000;     // 7.0f

	// quantiser front end to output stage
	typedef struct packed {
		logic       valid;
		logic [7:0] byte_val;
		logic       last;
	} pack_req_t;
endpackage
`default_nettype wire

>>> hw/rtl/i4gq_fdiv.sv
// Iterative FP32 divider, one quotient bit per cycle, correctly rounded to nearest even
`default_nettype none
module i4gq_fdiv (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic             done,
	output logic [31:0] q
);
	logic        run_q;
	logic [4:0]  cnt_q;
	logic [25:0] rem_q;
	logic [24:0] den_q;
	logic [26:0] quo_q;
	logic        sgn_q, zero_q, inf_q, nan_q;
	logic [31:0] nan_bits_q;
	logic signed [10:0] exp_q;
	logic [25:0] rem_sh;
	logic        bit_now;

	// operand decode; subnormal dividends count as zero, finite divisors are normal
	logic [7:0] ea, eb;
	logic [23:0] ma, mb;
	logic        a_nan, a_inf, b_nan, b_inf;
	assign ea = a[30:23];
	assign eb = b[30:23];
	assign ma = {ea != 8'd0, a[22:0]};
	assign mb = {1'b1, b[22:0]};
	assign a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
	assign a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
	assign b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
	assign b_inf = (eb == 8'hFF) && (b[22:0] == 23'd0);

	assign rem_sh  = {rem_q[24:0], 1'b0};
	assign bit_now = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 5'd27;
				done  <= 1'b0;
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				run_q <= (cnt_q != 5'd1);
				done  <= (cnt_q == 5'd1);
			end else begin
				done <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sgn_q  <= a[31] ^ b[31];
			zero_q <= (ea == 8'd0) || b_inf;
			nan_q  <= a_nan || b_nan || (a_inf && b_inf);
			inf_q  <= a_inf;
			den_q  <= {1'b0, mb};
			quo_q  <= '0;
			// NaN operands propagate quietened, otherwise the default NaN
			if (a_nan) begin
				nan_bits_q <= {a[31], 8'hFF, 1'b1, a[21:0]};
			end else if (b_nan) begin
				nan_bits_q <= {b[31], 8'hFF, 1'b1, b[21:0]};
			end else begin
				nan_bits_q <= 32'hFFC00000;
			end
			if (ma < mb) begin
				rem_q <= {1'b0, ma, 1'b0};
				exp_q <= $signed({3'b0, ea}) - $signed({3'b0, eb}) + 11'sd126;
			end else begin
				rem_q <= {2'b0, ma};
				exp_q <= $signed({3'b0, ea}) - $signed({3'b0, eb}) + 11'sd127;
			end
		end else if (run_q) begin
			if (cnt_q == 5'd27) begin
				// first bit: remainder already aligned
				quo_q <= {26'b0, 1'b1};
				rem_q <= rem_q - {1'b0, den_q};
			end else begin
				quo_q <= {quo_q[25:0], bit_now};
				rem_q <= bit_now ? rem_sh - {1'b0, den_q} : rem_sh;
			end
		end
	end

	// round to nearest even: quo_q holds 24 mantissa bits, guard and two lower bits; those and rem give sticky
	logic [23:0] mant;
	logic        grd, rnd, stk;
	logic [24:0] mr;
	logic signed [10:0] er;
	logic [31:0] norm;
	always_comb begin
		mant = quo_q[26:3];
		grd  = quo_q[2];
		rnd  = quo_q[1] | quo_q[0] | (rem_q != 0);
		stk  = rnd;
		mr   = {1'b0, mant} + {24'b0, grd & (stk | mant[0])};
		er   = exp_q;
		if (mr[24]) begin
			er = exp_q + 11'sd1;
		end
		if (er >= 11'sd255) begin
			norm = {sgn_q, 8'hFF, 23'b0};
		end else if (er <= 11'sd0) begin
			norm = {sgn_q, 31'b0}; // tiny, codes become 8 anyway
		end else begin
			norm = {sgn_q, er[7:0], mr[24] ? mr[23:1] : mr[22:0]};
		end
		if (nan_q) begin
			q = nan_bits_q;
		end else if (inf_q) begin
			q = {sgn_q, 8'hFF, 23'b0};
		end else if (zero_q) begin
			q = {sgn_q, 31'b0};
		end else begin
			q = norm;
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/int4_group_quantizer.sv
// Top level of the int4 group quantiser
// Weights are taken one per cycle, whenever busy is low, into a 64-entry group memory
// while the largest magnitude is tracked. On a group's last weight busy rises: the scale
// max/7 is formed by an iterative divider (a start, 27 quotient steps, then the result),
// then each of the 64 weights is read back and divided by the scale in the same divider,
// and busy falls once the last division is done. The 32 packed bytes appear one per strobe,
// in the cycle after each odd weight's division, the last one in the same cycle as busy
// falls; the receiver cannot hold them off.
`default_nettype none
module int4_group_quantizer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] weight_bf16,
	output logic             valid,
	output logic [7:0]       packed_byte,
	output logic [15:0]      group_scale,
	output logic             group_end
);
	localparam logic [1:0] StLoad = 2'd0, StScale = 2'd1, StRead = 2'd2, StDiv = 2'd3;
	localparam int IdxW = i4gq_pkg::IdxW;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(i4gq_pkg::GroupSize - 1);

	logic [1:0]      st_q;
	logic [IdxW-1:0] fill_q, rd_q;
	logic [14:0]     max_q;
	logic [31:0]     scale_q;
	logic [3:0]      lo_q;
	logic            go_q;
	logic [15:0]     mem [i4gq_pkg::GroupSize];
	logic [15:0]     rdata_s1;

	logic        d_start, d_done;
	logic [31:0] d_a, d_b, d_q;
	i4gq_pkg::pack_req_t req;

	assign busy = (st_q != StLoad);

	// group memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mem[fill_q] <= weight_bf16;
		end
		rdata_s1 <= mem[rd_q];
	end

	// round half away from zero, offset and clamp on the quotient
	function automatic logic [3:0] code_of(input logic [31:0] f);
		logic [7:0] e;
		logic [3:0] m;
		logic [3:0] r;
		e = f[30:23];
		m = 4'd0;
		if (e == 8'hFF && f[22:0] != 0) begin
			return 4'd8;
		end
		// |q| >= 7.5 saturates
		if (e > 8'd129 || (e == 8'd129 && f[22:20] >= 3'b111)) begin
			return f[31] ? 4'd0 : 4'd15;
		end
		if (e < 8'd126) begin
			r = 4'd0;
		end else begin
			// value in [0.5,7.5): integer part plus half bit
			m = {1'b1, f[22:20]} >> (8'd129 - e);
			r = (m >> 1) + {3'b0, m[0]};
		end
		return f[31] ? 4'd8 - r : 4'd8 + r;
	endfunction

	assign d_start = go_q;
	assign d_a = (st_q == StScale) ? {1'b0, max_q, 16'b0} : {rdata_s1, 16'b0};
	assign d_b = (st_q == StScale) ? i4gq_pkg::SevenF : scale_q;

	i4gq_fdiv u_div (
		.clk(clk), .arst_n(arst_n), .start(d_start), .a(d_a), .b(d_b),
		.done(d_done), .q(d_q)
	);

	// a byte goes out after each odd element, and after a lone last even element
	always_comb begin
		req.last     = rd_q == LastIdx;
		req.valid    = (st_q == StDiv) && d_done && (rd_q[0] || req.last);
		req.byte_val = rd_q[0] ? {code_of(d_q), lo_q} : {4'd0, code_of(d_q)};
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= StLoad;
			fill_q <= '0;
			rd_q   <= '0;
			max_q  <= '0;
			go_q   <= 1'b0;
			valid  <= 1'b0;
		end else begin
			go_q  <= ((st_q == StLoad) && start && (fill_q == LastIdx)) || (st_q == StRead);
			valid <= req.valid;
			unique case (st_q)
				StLoad: begin
					if (start) begin
						if (weight_bf16[14:0] > max_q) max_q <= weight_bf16[14:0];
						if (fill_q == LastIdx) begin
							fill_q <= '0;
							st_q   <= StScale;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				StScale: begin
					if (d_done) begin
						rd_q <= '0;
						st_q <= StRead;
					end
				end
				StRead: begin
					st_q <= StDiv;
				end
				StDiv: begin
					if (d_done) begin
						rd_q <= rd_q + 1'b1;
						if (req.last) begin
							st_q  <= StLoad;
							max_q <= '0;
						end else begin
							st_q <= StRead;
						end
					end
				end
				default: st_q <= StLoad;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (st_q == StScale && d_done) begin
			scale_q <= (d_q[30:0] < i4gq_pkg::ScaleFloor[30:0]) ? i4gq_pkg::ScaleFloor : d_q;
		end
		if (st_q == StDiv && d_done && !rd_q[0]) begin
			lo_q <= code_of(d_q);
		end
		if (req.valid) begin
			packed_byte <= req.byte_val;
			group_end   <= req.last;
		end
	end
	assign group_scale = scale_q[31:16];

	a_no_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(st_q) == StDiv) else $error("output outside division");
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && group_end) |=> st_q == StLoad) else $error("group end misplaced");
endmodule
`default_nettype wire

>>> test/tb_int4_group_quantizer.sv
// Self-checking testbench for the int4 group quantiser, with a bit-exact FP32 predictor
`default_nettype none
module tb_int4_group_quantizer;
	localparam int CycleLimit = 50000;

	typedef struct {
		logic [7:0]  byte_val;
		logic [15:0] scale;
		logic        last;
	} packed_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [15:0] weight_bf16 = '0;
	logic        busy;
	logic        valid;
	logic [7:0]  packed_byte;
	logic [15:0] group_scale;
	logic        group_end;

	// predictor state
	logic [15:0]  group_weights [i4gq_pkg::GroupSize];
	int           weights_held = 0;
	logic [14:0]  peak_magnitude = '0;
	packed_byte_t pending_bytes [$];

	int  fail_count = 0;
	int  cycle_count = 0;
	bit  gaps_on = 1'b1;

	int4_group_quantizer i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.weight_bf16(weight_bf16),
		.valid      (valid),
		.packed_byte(packed_byte),
		.group_scale(group_scale),
		.group_end  (group_end)
	);

	always #1 clk = ~clk;

	// FP32 bit pattern to an exact real
	function automatic real f32_value(input logic [31:0] b);
		logic [63:0] d;
		real r;
		d = '0;
		if (b[30:23] == 8'hFF) begin
			d = {b[31], 11'h7FF, b[22:0], 29'b0};
			return $bitstoreal(d);
		end
		if (b[30:23] == 8'h00) begin
			r = b[22:0] * (2.0 ** (-149));
			return b[31] ? -r : r;
		end
		d = {b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'b0};
		return $bitstoreal(d);
	endfunction

	// real to FP32, round to nearest even; double results below FP32 normal range go to zero
	function automatic logic [31:0] f32_round(input real x);
		logic [63:0] d;
		logic [24:0] mant;
		int          fe;
		logic        inc;
		d = $realtobits(x);
		if (d[62:52] == 11'h7FF)
			return {d[63], 8'hFF, d[51:29] | ((d[51:0] != 0) ? 23'h400000 : 23'h0)};
		fe = int'(d[62:52]) - 1023 + 127;
		if (d[62:52] == 11'h000 || fe <= 0)
			return {d[63], 31'b0};
		inc  = d[28] & ((|d[27:0]) | d[29]);
		mant = {2'b01, d[51:29]} + 25'(inc);
		if (mant[24])
			fe++;
		if (fe >= 255)
			return {d[63], 8'hFF, 23'b0};
		return {d[63], 8'(fe), mant[24] ? 23'b0 : mant[22:0]};
	endfunction

	// round half away from zero, offset by 8, clamp to 0..15
	function automatic logic [3:0] nibble_code(input logic [31:0] qb);
		real q;
		real a;
		int  i;
		if (qb[30:23] == 8'hFF && qb[22:0] != 0)
			return 4'd8;
		q = f32_value(qb);
		if (q >= 7.5)
			return 4'd15;
		if (q <= -7.5)
			return 4'd0;
		a = (q < 0.0) ? -q : q;
		i = 0;
		while (real'(i + 1) <= a)
			i++;
		if (a - real'(i) >= 0.5)
			i++;
		return 4'((q < 0.0 ? -i : i) + 8);
	endfunction

	// append one expected byte at the tail of the queue
	task automatic enqueue_byte(input packed_byte_t pb);
		pending_bytes.insert(pending_bytes.size(), pb);
	endtask

	// take one accepted weight; on a full group queue the packed bytes it yields
	task automatic absorb_weight(input logic [15:0] w);
		logic [31:0]  scale_bits;
		real          scale;
		logic [3:0]   lo;
		logic [3:0]   hi;
		packed_byte_t pb;
		group_weights[weights_held] = w;
		if (w[14:0] > peak_magnitude)
			peak_magnitude = w[14:0];
		weights_held++;
		if (weights_held == i4gq_pkg::GroupSize) begin
			scale_bits = f32_round(f32_value({1'b0, peak_magnitude, 16'b0}) / 7.0);
			if (!(scale_bits[30:23] == 8'hFF && scale_bits[22:0] != 0) &&
					f32_value(scale_bits) < f32_value(i4gq_pkg::ScaleFloor))
				scale_bits = i4gq_pkg::ScaleFloor;
			scale = f32_value(scale_bits);
			for (int k = 0; k < i4gq_pkg::NBytes; k++) begin
				lo = nibble_code(f32_round(f32_value({group_weights[2*k], 16'b0}) / scale));
				hi = 4'd0;
				if (2*k + 1 < i4gq_pkg::GroupSize)
					hi = nibble_code(f32_round(f32_value({group_weights[2*k+1], 16'b0}) / scale));
				pb.byte_val = {hi, lo};
				pb.scale    = scale_bits[31:16];
				pb.last     = (k == i4gq_pkg::NBytes - 1);
				enqueue_byte(pb);
			end
			weights_held = 0;
			peak_magnitude = '0;
		end
	endtask

	// accepted requests feed the predictor at the accepting edge
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			absorb_weight(weight_bf16);
	end

	// one request: optional idle burst, then hold start until accepted
	task automatic send_weight(input logic [15:0] w);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		start <= 1'b1;
		weight_bf16 <= w;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	// random weight near a chosen exponent
	function automatic logic [15:0] near_weight(input int base_exp);
		int e;
		if ($urandom_range(0, 15) == 0)
			return {1'($urandom), 15'b0};
		e = base_exp - $urandom_range(0, 4);
		if (e < 0)
			e = 0;
		return {1'($urandom), 8'(e), 7'($urandom)};
	endfunction

	function automatic logic [15:0] any_finite();
		logic [15:0] w;
		w = 16'($urandom);
		if (w[14:7] == 8'hFF)
			w[14:7] = 8'hFE;
		return w;
	endfunction

	// result checker: the block cannot be held off, so every strobe is a result
	always @(posedge clk) begin
		packed_byte_t pb;
		if (arst_n && valid) begin
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected byte, expected none, actual %h scale %h end %b",
					$time, packed_byte, group_scale, group_end);
				fail_count++;
			end else begin
				pb = pending_bytes.pop_front();
				if (packed_byte !== pb.byte_val) begin
					$display("%0t: packed_byte expected %h actual %h", $time, pb.byte_val, packed_byte);
					fail_count++;
				end
				if (group_scale !== pb.scale) begin
					$display("%0t: group_scale expected %h actual %h", $time, pb.scale, group_scale);
					fail_count++;
				end
				if (group_end !== pb.last) begin
					$display("%0t: group_end expected %b actual %b", $time, pb.last, group_end);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// zeros, subnormals and tiny normals: scale floored, codes from the floor
	task automatic test_floor_group();
		logic [15:0] tiny [9] = '{16'h0000, 16'h8000, 16'h0001, 16'h8001, 16'h007F, 16'h0080,
			16'h3300, 16'hB2C0, 16'h322B};
		for (int i = 0; i < i4gq_pkg::GroupSize; i++)
			send_weight(i < 9 ? tiny[i] : ((i % 2) ? 16'h8000 : 16'h0000));
	endtask

	// max 7.0 gives scale 1.0, so halves check rounding away from zero
	task automatic test_tie_rounding();
		logic [15:0] ties [16] = '{16'h40E0, 16'h3F00, 16'hBF00, 16'h3FC0, 16'hBFC0, 16'h4020,
			16'hC020, 16'h4060, 16'hC060, 16'h40D0, 16'hC0D0, 16'hC0E0, 16'h0001, 16'h8001,
			16'h007F, 16'h0080};
		for (int i = 0; i < i4gq_pkg::GroupSize; i++)
			send_weight(i < 16 ? ties[i] : near_weight(128));
	endtask

	// largest finite magnitudes with a wide spread of neighbours
	task automatic test_extremes();
		logic [15:0] ext [6] = '{16'h7F7F, 16'hFF7F, 16'h7F00, 16'hFF00, 16'h0001, 16'h8080};
		for (int i = 0; i < i4gq_pkg::GroupSize; i++) begin
			if (i < 6)
				send_weight(ext[i]);
			else if ($urandom_range(0, 7) == 0)
				send_weight(any_finite());
			else
				send_weight(near_weight(254));
		end
	endtask

	// infinite weights and a signalling NaN magnitude that sets the scale
	task automatic test_non_finite();
		for (int i = 0; i < i4gq_pkg::GroupSize; i++)
			send_weight(i == 5 ? 16'hFF80 : (i == 6 ? 16'h7F80 :
				(i == 9 ? 16'h7F81 : any_finite())));
	endtask

	// sender holds off until every outstanding byte is out
	task automatic test_drain_pause();
		start <= 1'b0;
		@(posedge clk);
		while (pending_bytes.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_floor_group();
		test_tie_rounding();
		test_drain_pause();
		test_extremes();
		gaps_on = 1'b0;
		test_non_finite();
		start <= 1'b0;
		@(posedge clk);
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
